[rtl/gradient_noise_lattice_core_defines.svh]
// Assertion macros shared by the gradient noise lattice RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GRADIENT_NOISE_LATTICE_CORE_DEFINES_SVH
`define GRADIENT_NOISE_LATTICE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GNL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GNL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gnl_pkg.sv]
// Shared types and constants of the gradient noise lattice block.
// No dependencies.
package gnl_pkg;

  localparam int COORD_W = 28;
  localparam int GRAD_W  = 16;
  localparam int NOISE_W = 16;
  localparam int CELL_W  = 8;
  localparam int IDX_W   = 10;
  localparam int MODE_W  = 3;

  localparam logic [MODE_W-1:0] MODE_EVAL_1D   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EVAL_2D   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EVAL_3D   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD_PERM = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOAD_GRAD = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } eval_item_t;

  typedef struct packed {
    logic                     perm_we;
    logic                     grad_we;
    logic [IDX_W-1:0]         addr;
    logic [CELL_W-1:0]        perm;
    logic signed [GRAD_W-1:0] g1;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gz;
  } tbl_wr_t;

endpackage

[rtl/gnl_if.sv]
// Channel interfaces of the gradient noise lattice block.
// Depends on nothing; widths match gnl_pkg.
interface gnl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [9:0]         table_index;
  logic [7:0]         perm_value;
  logic signed [15:0] grad_one;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic signed [27:0] coord_x;
  logic signed [27:0] coord_y;
  logic signed [27:0] coord_z;
  modport source(output valid, mode, table_index, perm_value, grad_one, grad_x, grad_y,
                 grad_z, coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, mode, table_index, perm_value, grad_one, grad_x, grad_y,
               grad_z, coord_x, coord_y, coord_z, output ready);
endinterface

interface gnl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;
  modport source(output valid, noise_value, input ready);
  modport sink(input valid, noise_value, output ready);
endinterface

interface gnl_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[rtl/gnl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 514,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/gnl_queue.sv]
// Small FIFO of evaluation items between the front and the back end.
// Depends on gnl_pkg and the assertion macro header.
`include "gradient_noise_lattice_core_defines.svh"
module gnl_queue import gnl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  eval_item_t push_item,
  output logic       full,
  input  logic       pop,
  output eval_item_t head,
  output logic       head_valid
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  eval_item_t      slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign full       = (cnt_r == CNTW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];

  `GNL_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNTW'(DEPTH), "queue count exceeds depth")
  `GNL_ASSERT_IMPL(a_pop_nonempty, pop, cnt_r != '0, "pop from empty queue")
  `GNL_ASSERT_NEXT(a_push_count, push && !pop, cnt_r == CNTW'($past(cnt_r) + 1'b1),
                   "push did not raise queue count")

endmodule

[rtl/gnl_front.sv]
// Front end: accepts input beats, classifies them, issues table writes and
// queues evaluations. Holds the lattice mask register. Depends on gnl_pkg, gnl_if.
module gnl_front import gnl_pkg::*; #(
  parameter int TABLE_DEPTH = 514
) (
  input  logic        clk,
  input  logic        rst_n,
  gnl_in_if.sink      in_bus,
  gnl_cfg_if.sink     cfg_bus,
  input  logic        q_full,
  input  logic        busy,
  output logic        push,
  output eval_item_t  push_item,
  output tbl_wr_t     tbl_wr,
  output logic [7:0]  lattice_mask
);

  logic [7:0] mask_r;
  logic       is_eval, is_load, in_ready, idx_ok, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 8'hFF;
    end else if (cfg_bus.valid) begin
      mask_r <= cfg_bus.data;
    end
  end

  assign cfg_bus.ready = 1'b1;
  assign lattice_mask  = mask_r;

  always_comb begin
    is_eval = 1'b0;
    is_load = 1'b0;
    unique case (in_bus.mode) inside
      MODE_EVAL_1D, MODE_EVAL_2D, MODE_EVAL_3D: is_eval = 1'b1;
      MODE_LOAD_PERM, MODE_LOAD_GRAD:           is_load = 1'b1;
      default: ;
    endcase
  end

  assign in_ready     = is_eval ? !q_full : (is_load ? !busy : 1'b1);
  assign in_bus.ready = in_ready;
  assign take         = in_bus.valid && in_ready;
  assign idx_ok       = (32'(in_bus.table_index) < 32'(TABLE_DEPTH));

  assign push           = take && is_eval;
  assign push_item.mode = in_bus.mode;
  assign push_item.cx   = in_bus.coord_x;
  assign push_item.cy   = in_bus.coord_y;
  assign push_item.cz   = in_bus.coord_z;

  assign tbl_wr.perm_we = take && idx_ok && (in_bus.mode == MODE_LOAD_PERM);
  assign tbl_wr.grad_we = take && idx_ok && (in_bus.mode == MODE_LOAD_GRAD);
  assign tbl_wr.addr    = in_bus.table_index;
  assign tbl_wr.perm    = in_bus.perm_value;
  assign tbl_wr.g1      = in_bus.grad_one;
  assign tbl_wr.gx      = in_bus.grad_x;
  assign tbl_wr.gy      = in_bus.grad_y;
  assign tbl_wr.gz      = in_bus.grad_z;

endmodule

[rtl/gnl_back.sv]
// Back end: table lookups on replicated RAMs, gradient dot products,
// smoothstep weights, blend tree and saturation. Depends on gnl_pkg, gnl_if, gnl_ram.
module gnl_back import gnl_pkg::*; #(
  parameter int TABLE_DEPTH = 514,
  parameter int FRAC_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] lattice_mask,
  input  tbl_wr_t    tbl_wr,
  input  logic       head_valid,
  input  eval_item_t head,
  output logic       head_pop,
  output logic       busy,
  gnl_out_if.source  out_bus
);

  localparam int F    = FRAC_BITS;
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int HW   = 9;
  localparam int RW   = F + 1;
  localparam int PW   = RW + GRAD_W;
  localparam int SUMW = PW + 2;
  localparam int CW   = 20;
  localparam int SSW  = F + 1;
  localparam int DW   = CW + 1;
  localparam int MW   = SSW + 1 + DW;
  localparam int GWW  = 4 * GRAD_W;
  localparam int NSTG = 10;
  localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;
  localparam logic signed [CW-1:0] SAT_HI = 20'sd32767;
  localparam logic signed [CW-1:0] SAT_LO = -20'sd32768;

  logic adv;
  logic out_valid_r;
  logic signed [NOISE_W-1:0] noise_r;
  logic [NSTG:1] vld_r;
  logic [MODE_W-1:0] mode_r [1:NSTG];

  assign adv      = !out_valid_r || out_bus.ready;
  assign head_pop = adv && head_valid;
  assign busy     = vld_r[1] || vld_r[2];

  // Stage 0: split coordinates, square fractions, first permutation lookup.
  logic signed [COORD_W-1:0] crd [3];
  logic [CELL_W-1:0] cl0 [3], cl1 [3];
  logic [F-1:0] fr0 [3];
  logic [F-1:0] q0 [3];
  logic [1:0] pf0;

  assign crd[0] = head.cx;
  assign crd[1] = head.cy;
  assign crd[2] = head.cz;

  always_comb begin
    logic [2*F-1:0] sq;
    for (int k = 0; k < 3; k++) begin
      cl0[k] = CELL_W'(crd[k] >>> F) & lattice_mask;
      cl1[k] = (cl0[k] + 8'd1) & lattice_mask;
      fr0[k] = crd[k][F-1:0];
      sq     = (2*F)'(fr0[k]) * (2*F)'(fr0[k]);
      q0[k]  = sq[2*F-1:F];
    end
    pf0[0] = (32'(cl0[0]) < 32'(TABLE_DEPTH));
    pf0[1] = (32'(cl1[0]) < 32'(TABLE_DEPTH));
  end

  logic [CELL_W-1:0] cl0_1_r [3], cl1_1_r [3];
  logic [F-1:0] fr_1_r [3], q_1_r [3];
  logic [1:0] pf_1_r;
  logic [CELL_W-1:0] prd1 [2];

  gnl_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_DEPTH)) u_perm_a0 (
    .clk(clk), .we(tbl_wr.perm_we), .waddr(AW'(tbl_wr.addr)), .wdata(tbl_wr.perm),
    .re(adv), .raddr(AW'(cl0[0])), .rdata(prd1[0]));
  gnl_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_DEPTH)) u_perm_a1 (
    .clk(clk), .we(tbl_wr.perm_we), .waddr(AW'(tbl_wr.addr)), .wdata(tbl_wr.perm),
    .re(adv), .raddr(AW'(cl1[0])), .rdata(prd1[1]));

  // Stage 1: second permutation level and smoothstep weights.
  logic [CELL_W-1:0] p1 [2];
  logic [HW-1:0] hp1 [4];
  logic [3:0] hf1;
  logic [SSW-1:0] s1 [3];

  always_comb begin
    logic [F+1:0] t;
    logic [2*F+1:0] prod;
    for (int j = 0; j < 2; j++) begin
      p1[j] = pf_1_r[j] ? prd1[j] : '0;
    end
    for (int k = 0; k < 4; k++) begin
      hp1[k] = {1'b0, p1[k % 2]} + {1'b0, ((k / 2) == 1) ? cl1_1_r[1] : cl0_1_r[1]};
      hf1[k] = (32'(hp1[k]) < 32'(TABLE_DEPTH));
    end
    for (int k = 0; k < 3; k++) begin
      t     = THREE_ONE - {1'b0, fr_1_r[k], 1'b0};
      prod  = (2*F+2)'(q_1_r[k]) * (2*F+2)'(t);
      s1[k] = prod[2*F:F];
    end
  end

  logic [CELL_W-1:0] hrd2 [4];

  for (genvar k = 0; k < 4; k++) begin : g_perm_b
    gnl_ram #(.WIDTH(CELL_W), .DEPTH(TABLE_DEPTH)) u_perm_b (
      .clk(clk), .we(tbl_wr.perm_we), .waddr(AW'(tbl_wr.addr)), .wdata(tbl_wr.perm),
      .re(adv), .raddr(AW'(hp1[k])), .rdata(hrd2[k]));
  end

  logic [CELL_W-1:0] p_2_r [2];
  logic [CELL_W-1:0] bz0_2_r, bz1_2_r;
  logic [F-1:0] fr_2_r [3];
  logic [SSW-1:0] s_2_r [3];
  logic [3:0] hf_2_r;

  // Stage 2: gradient addresses per corner.
  logic [CELL_W-1:0] h2 [4];
  logic [HW-1:0] ga2 [8];
  logic [7:0] gf2;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h2[k] = hf_2_r[k] ? hrd2[k] : '0;
    end
    for (int c = 0; c < 8; c++) begin
      unique case (mode_r[2])
        MODE_EVAL_1D: ga2[c] = (c < 2) ? {1'b0, p_2_r[c % 2]} : '0;
        MODE_EVAL_2D: ga2[c] = {1'b0, h2[c % 4]};
        MODE_EVAL_3D: ga2[c] = {1'b0, h2[c % 4]} + {1'b0, (c >= 4) ? bz1_2_r : bz0_2_r};
        default:      ga2[c] = '0;
      endcase
      gf2[c] = (32'(ga2[c]) < 32'(TABLE_DEPTH));
    end
  end

  logic [GWW-1:0] grd3 [8];

  for (genvar c = 0; c < 8; c++) begin : g_grad
    gnl_ram #(.WIDTH(GWW), .DEPTH(TABLE_DEPTH)) u_grad (
      .clk(clk), .we(tbl_wr.grad_we), .waddr(AW'(tbl_wr.addr)),
      .wdata({tbl_wr.g1, tbl_wr.gx, tbl_wr.gy, tbl_wr.gz}),
      .re(adv), .raddr(AW'(ga2[c])), .rdata(grd3[c]));
  end

  logic [F-1:0] fr_3_r [3];
  logic [SSW-1:0] s_3_r [3];
  logic [7:0] gf_3_r;

  // Stage 3: gradient times offset products.
  logic signed [PW-1:0] px3 [8], py3 [8], pz3 [8];

  always_comb begin
    logic [GWW-1:0] g;
    logic signed [GRAD_W-1:0] gxe, gye, gze;
    logic signed [RW-1:0] ox, oy, oz;
    for (int c = 0; c < 8; c++) begin
      g   = gf_3_r[c] ? grd3[c] : '0;
      gxe = (mode_r[3] == MODE_EVAL_1D) ? g[4*GRAD_W-1:3*GRAD_W] : g[3*GRAD_W-1:2*GRAD_W];
      gye = g[2*GRAD_W-1:GRAD_W];
      gze = g[GRAD_W-1:0];
      ox  = c[0] ? signed'({1'b1, fr_3_r[0]}) : signed'({1'b0, fr_3_r[0]});
      oy  = c[1] ? signed'({1'b1, fr_3_r[1]}) : signed'({1'b0, fr_3_r[1]});
      oz  = c[2] ? signed'({1'b1, fr_3_r[2]}) : signed'({1'b0, fr_3_r[2]});
      if (mode_r[3] == MODE_EVAL_1D) begin
        oy = '0;
      end
      if (mode_r[3] != MODE_EVAL_3D) begin
        oz = '0;
      end
      px3[c] = PW'(gxe) * PW'(ox);
      py3[c] = PW'(gye) * PW'(oy);
      pz3[c] = PW'(gze) * PW'(oz);
    end
  end

  logic signed [PW-1:0] px_4_r [8], py_4_r [8], pz_4_r [8];
  logic [SSW-1:0] s_4_r [3];

  // Stage 4: corner values.
  logic signed [CW-1:0] cr4 [8];

  always_comb begin
    logic signed [SUMW-1:0] sum;
    for (int c = 0; c < 8; c++) begin
      sum    = SUMW'(px_4_r[c]) + SUMW'(py_4_r[c]) + SUMW'(pz_4_r[c]);
      cr4[c] = CW'(sum >>> F);
    end
  end

  logic signed [CW-1:0] cr_5_r [8];
  logic [SSW-1:0] s_5_r [3];

  // Stage 5: x blend products.
  logic signed [MW-1:0] m5 [4];

  always_comb begin
    logic signed [DW-1:0] d;
    logic signed [SSW:0] sv;
    sv = signed'({1'b0, s_5_r[0]});
    for (int j = 0; j < 4; j++) begin
      d     = DW'(cr_5_r[2*j+1]) - DW'(cr_5_r[2*j]);
      m5[j] = MW'(sv) * MW'(d);
    end
  end

  logic signed [CW-1:0] a_6_r [4];
  logic signed [MW-1:0] m_6_r [4];
  logic [SSW-1:0] s_6_r [3];

  // Stage 6: x blend sums.
  logic signed [CW-1:0] bx6 [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bx6[j] = a_6_r[j] + CW'(m_6_r[j] >>> F);
    end
  end

  logic signed [CW-1:0] bx_7_r [4];
  logic [SSW-1:0] s_7_r [3];

  // Stage 7: y blend products.
  logic signed [MW-1:0] m7 [2];

  always_comb begin
    logic signed [DW-1:0] d;
    logic signed [SSW:0] sv;
    sv = signed'({1'b0, s_7_r[1]});
    for (int k = 0; k < 2; k++) begin
      d     = DW'(bx_7_r[2*k+1]) - DW'(bx_7_r[2*k]);
      m7[k] = MW'(sv) * MW'(d);
    end
  end

  logic signed [CW-1:0] a_8_r [2];
  logic signed [MW-1:0] m_8_r [2];
  logic signed [CW-1:0] bx0_8_r;
  logic [SSW-1:0] sz_8_r;

  // Stage 8: y blend sums.
  logic signed [CW-1:0] by8 [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      by8[k] = a_8_r[k] + CW'(m_8_r[k] >>> F);
    end
  end

  logic signed [CW-1:0] by_9_r [2];
  logic signed [CW-1:0] bx0_9_r;
  logic [SSW-1:0] sz_9_r;

  // Stage 9: z blend product.
  logic signed [MW-1:0] m9;
  logic signed [DW-1:0] d9;
  logic signed [SSW:0] sv9;

  assign d9  = DW'(by_9_r[1]) - DW'(by_9_r[0]);
  assign sv9 = signed'({1'b0, sz_9_r});
  assign m9  = MW'(sv9) * MW'(d9);

  logic signed [CW-1:0] a_10_r, bx0_10_r;
  logic signed [MW-1:0] m_10_r;

  // Stage 10: final select and saturation.
  logic signed [CW-1:0] res10;
  logic signed [NOISE_W-1:0] sat10;

  always_comb begin
    unique case (mode_r[NSTG])
      MODE_EVAL_1D: res10 = bx0_10_r;
      MODE_EVAL_2D: res10 = a_10_r;
      default:      res10 = a_10_r + CW'(m_10_r >>> F);
    endcase
    if (res10 > SAT_HI) begin
      sat10 = 16'sh7FFF;
    end else if (res10 < SAT_LO) begin
      sat10 = -16'sh8000;
    end else begin
      sat10 = res10[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r[1] <= head.mode;
      for (int k = 2; k <= NSTG; k++) begin
        mode_r[k] <= mode_r[k-1];
      end
      cl0_1_r  <= cl0;
      cl1_1_r  <= cl1;
      fr_1_r   <= fr0;
      q_1_r    <= q0;
      pf_1_r   <= pf0;
      p_2_r    <= p1;
      bz0_2_r  <= cl0_1_r[2];
      bz1_2_r  <= cl1_1_r[2];
      fr_2_r   <= fr_1_r;
      s_2_r    <= s1;
      hf_2_r   <= hf1;
      fr_3_r   <= fr_2_r;
      s_3_r    <= s_2_r;
      gf_3_r   <= gf2;
      px_4_r   <= px3;
      py_4_r   <= py3;
      pz_4_r   <= pz3;
      s_4_r    <= s_3_r;
      cr_5_r   <= cr4;
      s_5_r    <= s_4_r;
      for (int j = 0; j < 4; j++) begin
        a_6_r[j] <= cr_5_r[2*j];
      end
      m_6_r    <= m5;
      s_6_r    <= s_5_r;
      bx_7_r   <= bx6;
      s_7_r    <= s_6_r;
      a_8_r[0] <= bx_7_r[0];
      a_8_r[1] <= bx_7_r[2];
      m_8_r    <= m7;
      bx0_8_r  <= bx_7_r[0];
      sz_8_r   <= s_7_r[2];
      by_9_r   <= by8;
      bx0_9_r  <= bx0_8_r;
      sz_9_r   <= sz_8_r;
      a_10_r   <= by_9_r[0];
      m_10_r   <= m9;
      bx0_10_r <= bx0_9_r;
      noise_r  <= sat10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSTG-1:1], head_valid};
      out_valid_r <= vld_r[NSTG];
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.noise_value = noise_r;

endmodule

[rtl/gradient_noise_lattice_core.sv]
// Classic lattice gradient noise in one, two or three dimensions.
// Depends on gnl_pkg, gnl_if, gnl_front, gnl_queue, gnl_back and the macro header.
//
// Evaluation beats are accepted one per cycle while the queue is not full, and
// each gives one noise value through the queue, a ten-stage pipeline and an
// output register; both lookup levels of the permutation table and all eight
// gradient corners are read in parallel from replicated RAM copies. Load beats
// are accepted only once no queued or in-flight evaluation still has table
// reads pending (at most the four queue entries plus two pipeline stages).
// Beats with unused modes are taken and dropped. The tables need no clearing
// pass; they must be loaded before they are used.
`include "gradient_noise_lattice_core_defines.svh"
module gradient_noise_lattice_core import gnl_pkg::*; #(
  parameter int TABLE_DEPTH = 514,
  parameter int FRAC_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  gnl_in_if.sink    in_bus,
  gnl_out_if.source out_bus,
  gnl_cfg_if.sink   cfg_bus
);

  logic       q_full, push, pop, head_valid, back_busy, busy;
  eval_item_t push_item, head;
  tbl_wr_t    tbl_wr;
  logic [7:0] lattice_mask;

  assign busy = head_valid || back_busy;

  gnl_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .cfg_bus(cfg_bus),
    .q_full(q_full), .busy(busy), .push(push), .push_item(push_item),
    .tbl_wr(tbl_wr), .lattice_mask(lattice_mask));

  gnl_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .full(q_full),
    .pop(pop), .head(head), .head_valid(head_valid));

  gnl_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .lattice_mask(lattice_mask), .tbl_wr(tbl_wr),
    .head_valid(head_valid), .head(head), .head_pop(pop), .busy(back_busy),
    .out_bus(out_bus));

  `GNL_ASSERT_IMPL(a_write_idle, tbl_wr.perm_we || tbl_wr.grad_we, !busy,
                   "table write while evaluations pending")

endmodule

[bench/tb_gradient_noise_lattice_core.sv]
// Self-checking testbench for gradient_noise_lattice_core: loads the tables, evaluates noise
// in 1D, 2D and 3D under several lattice masks and compares each beat with a built-in predictor.
// Depends on gnl_pkg, gnl_if and the RTL of the block.
module tb_gradient_noise_lattice_core;
  import gnl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 514;
  localparam int FRAC_BITS_TB = 16;
  localparam int PERM_MAX = 63;
  localparam int LOADED = 2 * (PERM_MAX + 1);
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]         mode;
    logic [IDX_W-1:0]          idx;
    logic [CELL_W-1:0]         perm;
    logic signed [GRAD_W-1:0]  g1, gx, gy, gz;
    logic signed [COORD_W-1:0] cx, cy, cz;
  } beat_t;

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  gnl_in_if  in_if();
  gnl_out_if out_if();
  gnl_cfg_if cfg_if();

  gradient_noise_lattice_core dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_if), .out_bus(out_if), .cfg_bus(cfg_if)
  );

  logic [7:0] lattice_mask = 8'd255;
  logic [7:0] perm_mem [DEPTH];
  longint     grad1_mem [DEPTH];
  longint     gradx_mem [DEPTH];
  longint     grady_mem [DEPTH];
  longint     gradz_mem [DEPTH];
  logic signed [NOISE_W-1:0] pending_noise [$];
  int errors = 0;
  int burst_left = 0;
  int stall_pct = 0;

  function automatic longint perm_at(longint i);
    return (i < DEPTH) ? longint'(perm_mem[i]) : 0;
  endfunction

  function automatic longint smooth(longint r);
    longint q;
    q = (r * r) >>> FRAC_BITS_TB;
    return (q * (3 * 65536 - 2 * r)) >>> FRAC_BITS_TB;
  endfunction

  function automatic longint lerp(longint s, longint a, longint b);
    return a + ((s * (b - a)) >>> FRAC_BITS_TB);
  endfunction

  function automatic longint corner3(longint i, longint x, longint y, longint z, bit use_z);
    if (i >= DEPTH) return 0;
    return (gradx_mem[i] * x + grady_mem[i] * y + (use_z ? gradz_mem[i] * z : 0))
           >>> FRAC_BITS_TB;
  endfunction

  function automatic void split_coord(longint c, output longint b0, output longint b1,
                                      output longint r0, output longint r1);
    b0 = (c >>> FRAC_BITS_TB) & longint'(lattice_mask);
    b1 = (b0 + 1) & longint'(lattice_mask);
    r0 = c & 65535;
    r1 = r0 - 65536;
  endfunction

  // Applies one beat to the model state; returns 1 with the noise value for evaluations.
  function automatic bit noise_step(beat_t b, output logic signed [NOISE_W-1:0] noise);
    longint bx0, bx1, by0, by1, bz0, bz1, rx0, rx1, ry0, ry1, rz0, rz1;
    longint sx, sy, sz, res, h00, h10, h01, h11, a, c, d, e;
    noise = '0;
    if (b.mode == MODE_LOAD_PERM || b.mode == MODE_LOAD_GRAD) begin
      if (b.idx < DEPTH) begin
        if (b.mode == MODE_LOAD_PERM) begin
          perm_mem[b.idx] = b.perm;
        end else begin
          grad1_mem[b.idx] = longint'(b.g1);
          gradx_mem[b.idx] = longint'(b.gx);
          grady_mem[b.idx] = longint'(b.gy);
          gradz_mem[b.idx] = longint'(b.gz);
        end
      end
      return 0;
    end
    if (b.mode > MODE_LOAD_GRAD) return 0;
    split_coord(longint'(b.cx), bx0, bx1, rx0, rx1);
    sx = smooth(rx0);
    if (b.mode == MODE_EVAL_1D) begin
      a = (rx0 * grad1_mem[perm_at(bx0)]) >>> FRAC_BITS_TB;
      c = (rx1 * grad1_mem[perm_at(bx1)]) >>> FRAC_BITS_TB;
      res = lerp(sx, a, c);
    end else begin
      split_coord(longint'(b.cy), by0, by1, ry0, ry1);
      sy = smooth(ry0);
      h00 = perm_at(perm_at(bx0) + by0);
      h10 = perm_at(perm_at(bx1) + by0);
      h01 = perm_at(perm_at(bx0) + by1);
      h11 = perm_at(perm_at(bx1) + by1);
      if (b.mode == MODE_EVAL_2D) begin
        a = lerp(sx, corner3(h00, rx0, ry0, 0, 0), corner3(h10, rx1, ry0, 0, 0));
        c = lerp(sx, corner3(h01, rx0, ry1, 0, 0), corner3(h11, rx1, ry1, 0, 0));
        res = lerp(sy, a, c);
      end else begin
        split_coord(longint'(b.cz), bz0, bz1, rz0, rz1);
        sz = smooth(rz0);
        a = lerp(sx, corner3(h00 + bz0, rx0, ry0, rz0, 1), corner3(h10 + bz0, rx1, ry0, rz0, 1));
        c = lerp(sx, corner3(h01 + bz0, rx0, ry1, rz0, 1), corner3(h11 + bz0, rx1, ry1, rz0, 1));
        d = lerp(sy, a, c);
        a = lerp(sx, corner3(h00 + bz1, rx0, ry0, rz1, 1), corner3(h10 + bz1, rx1, ry0, rz1, 1));
        c = lerp(sx, corner3(h01 + bz1, rx0, ry1, rz1, 1), corner3(h11 + bz1, rx1, ry1, rz1, 1));
        e = lerp(sy, a, c);
        res = lerp(sz, d, e);
      end
    end
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    noise = res[15:0];
    return 1;
  endfunction

  function automatic logic signed [GRAD_W-1:0] rand_grad();
    return GRAD_W'($urandom_range(0, 32768)) - 16'sd16384;
  endfunction

  // With a wide mask the cells stay low so that every lookup hits a loaded entry.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    if (lattice_mask > 8'(PERM_MAX)) return COORD_W'($urandom_range(0, PERM_MAX * 65536 - 1));
    if ($urandom_range(0, 3) == 0) return COORD_W'($urandom_range(0, 2 * 65536 * 20)) - 28'sd1310720;
    return COORD_W'($urandom);
  endfunction

  function automatic beat_t eval_beat(logic [MODE_W-1:0] mode, logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    beat_t b;
    b.mode = mode; b.idx = IDX_W'($urandom); b.perm = CELL_W'($urandom);
    b.g1 = GRAD_W'($urandom); b.gx = GRAD_W'($urandom);
    b.gy = GRAD_W'($urandom); b.gz = GRAD_W'($urandom);
    b.cx = x; b.cy = y; b.cz = z;
    return b;
  endfunction

  function automatic beat_t load_beat(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
    beat_t b;
    b = eval_beat(mode, rand_coord(), rand_coord(), rand_coord());
    b.idx = idx;
    b.perm = CELL_W'($urandom_range(0, PERM_MAX));
    b.g1 = rand_grad(); b.gx = rand_grad(); b.gy = rand_grad(); b.gz = rand_grad();
    return b;
  endfunction

  function automatic beat_t rand_eval();
    return eval_beat(MODE_W'($urandom_range(MODE_EVAL_1D, MODE_EVAL_3D)),
                     rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic send_beat(beat_t b);
    logic signed [NOISE_W-1:0] noise;
    in_if.valid <= 1'b1;
    in_if.mode <= b.mode; in_if.table_index <= b.idx; in_if.perm_value <= b.perm;
    in_if.grad_one <= b.g1; in_if.grad_x <= b.gx; in_if.grad_y <= b.gy; in_if.grad_z <= b.gz;
    in_if.coord_x <= b.cx; in_if.coord_y <= b.cy; in_if.coord_z <= b.cz;
    do @(negedge clk); while (!in_if.ready);
    if (noise_step(b, noise)) pending_noise.push_back(noise);
    @(posedge clk);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_noise.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mask(logic [7:0] mask);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= mask;
    do @(negedge clk); while (!cfg_if.ready);
    lattice_mask = mask;
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_noise.size() == 0) begin
        $error("noise_value: unexpected beat 0x%h", out_if.noise_value);
        errors++;
      end else begin
        if (out_if.noise_value !== pending_noise[0]) begin
          $error("noise_value: expected %0d, actual %0d", pending_noise[0], out_if.noise_value);
          errors++;
        end
        void'(pending_noise.pop_front());
      end
    end
  end

  task automatic test_table_load();
    for (int i = 0; i < LOADED; i++) send_beat(load_beat(MODE_LOAD_PERM, IDX_W'(i)));
    for (int i = 0; i < LOADED; i++) begin
      beat_t b;
      b = load_beat(MODE_LOAD_GRAD, IDX_W'(i));
      if (i == 3) begin
        b.g1 = 16'sd16384; b.gx = 16'sd16384; b.gy = 16'sd16384; b.gz = 16'sd16384;
      end else if (i == 5) begin
        b.g1 = -16'sd16384; b.gx = -16'sd16384; b.gy = -16'sd16384; b.gz = -16'sd16384;
      end
      send_beat(b);
    end
    send_beat(load_beat(MODE_LOAD_PERM, IDX_W'(DEPTH)));
    send_beat(load_beat(MODE_LOAD_GRAD, 10'h3FF));
  endtask

  task automatic test_directed();
    logic signed [COORD_W-1:0] pts [6];
    pts = '{28'sh8000000, 28'sh7FFFFFF, 28'sd0, -28'sd1, 28'sh000FFFF, 28'sh0010000};
    write_mask(8'(PERM_MAX));
    for (int i = 0; i < 6; i++) begin
      send_beat(eval_beat(MODE_EVAL_1D, pts[i], pts[5 - i], pts[i]));
      send_beat(eval_beat(MODE_EVAL_2D, pts[i], pts[(i + 1) % 6], pts[i]));
      send_beat(eval_beat(MODE_EVAL_3D, pts[i], pts[(i + 2) % 6], pts[(i + 3) % 6]));
    end
    for (logic [MODE_W-1:0] m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      send_beat(load_beat(m, IDX_W'($urandom_range(0, DEPTH - 1))));
      if (m == MODE_SPARE_HI) break;
    end
  endtask

  task automatic test_random_mix(int count);
    beat_t b;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0: b = load_beat(MODE_LOAD_PERM, IDX_W'($urandom_range(0, LOADED - 1)));
        1: b = load_beat(MODE_LOAD_GRAD, IDX_W'($urandom_range(0, LOADED - 1)));
        2: b = load_beat(MODE_W'($urandom_range(MODE_LOAD_PERM, MODE_SPARE_HI)),
                         IDX_W'($urandom_range(DEPTH, 1023)));
        default: b = rand_eval();
      endcase
      send_beat(b);
      if (n == count / 2) drain();
    end
  endtask

  task automatic test_lattice_masks();
    logic [7:0] masks [5];
    masks = '{8'd1, 8'd7, 8'h25, 8'd63, 8'd255};
    foreach (masks[i]) begin
      write_mask(masks[i]);
      stall_pct = (i % 2) ? 0 : 40;
      test_random_mix(60);
    end
  endtask

  initial begin
    in_if.valid = 0; in_if.mode = MODE_EVAL_1D; in_if.table_index = 0; in_if.perm_value = 0;
    in_if.grad_one = 0; in_if.grad_x = 0; in_if.grad_y = 0; in_if.grad_z = 0;
    in_if.coord_x = 0; in_if.coord_y = 0; in_if.coord_z = 0;
    cfg_if.valid = 0; cfg_if.data = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stall_pct = 30;
    test_table_load();
    test_directed();
    test_lattice_masks();
    stall_pct = 60;
    test_random_mix(70);
    drain();
    if (errors == 0) begin
      $display("gradient_noise_lattice_core test passed");
    end else begin
      $display("gradient_noise_lattice_core test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("gradient_noise_lattice_core test failed");
    $finish;
  end
endmodule
